>>> hdl/rfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfp_pkg: shared types and constants for the request queue with purge
// Command and result payloads, action and result codes, controller states
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rfp_pkg;

    localparam int DEPTH_DEFAULT     = 16;
    localparam int KEY_WIDTH_DEFAULT = 32;

    localparam int KEY_W      = 32;
    localparam int SIZE_W     = 32;
    localparam int REMOVED_W  = 5;
    localparam int REMOVED_MAX = 31;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_ABORT  = 2'd1,
        ACT_FETCH  = 2'd2,
        ACT_PRINT  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_APPENDED    = 3'd0,
        KIND_REJECTED    = 3'd1,
        KIND_ABORT_COUNT = 3'd2,
        KIND_FETCHED     = 3'd3,
        KIND_FETCH_EMPTY = 3'd4,
        KIND_PRINT_ENTRY = 3'd5,
        KIND_PRINT_EMPTY = 3'd6
    } kind_t;

    typedef struct packed {
        action_t                  action;
        logic [KEY_W-1:0]         req_key;
        logic signed [SIZE_W-1:0] req_size;
    } req_item_t;

    typedef struct packed {
        kind_t                    kind;
        logic [KEY_W-1:0]         out_key;
        logic signed [SIZE_W-1:0] out_size;
        logic [REMOVED_W-1:0]     removed;
        logic                     last;
    } rsp_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APPEND,
        ST_FETCH,
        ST_FETCH_OUT,
        ST_PRINT,
        ST_PRINT_OUT,
        ST_ABORT,
        ST_ABORT_SCAN,
        ST_ABORT_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic  latch;        // capture the request, clear scan indexes
        logic  append_wr;    // write the request at the tail
        logic  rd_en;        // read entry head+rd_idx, advance rd_idx
        logic  abort_wr;     // keep the entry just read: write at head+wr_idx
        logic  commit_abort; // occupancy takes the kept count
        logic  pop;          // drop the head entry
        logic  emit;         // load the result register
        kind_t emit_kind;
        logic  emit_data;    // result carries the entry just read
        logic  emit_last;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic rd_done;   // every stored entry has been read
        logic match;     // entry just read has the request key
        logic out_free;  // result register can take a new result
    } dpath_status_t;

endpackage
`default_nettype wire

>>> hdl/rfp_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfp_dpath: entry memory, queue pointers and result register
// Circular store of key/size entries with one write and one registered read
// port, head pointer, occupancy, scan indexes and the output register.
// ----------------------------------------------------------------------------
module rfp_dpath #(
    parameter int DEPTH     = rfp_pkg::DEPTH_DEFAULT,
    parameter int KEY_WIDTH = rfp_pkg::KEY_WIDTH_DEFAULT
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  rfp_pkg::req_item_t      req,
    input  rfp_pkg::ctrl_cmd_t      cmd,
    input  wire                     rsp_ready,
    output logic                    rsp_valid,
    output rfp_pkg::rsp_item_t      rsp,
    output rfp_pkg::dpath_status_t  status
);

    localparam int KSW = (KEY_WIDTH < rfp_pkg::KEY_W) ? KEY_WIDTH : rfp_pkg::KEY_W;
    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int EW  = KSW + rfp_pkg::SIZE_W;
    localparam int XW  = (CW > rfp_pkg::REMOVED_W) ? CW : rfp_pkg::REMOVED_W;

    logic [EW-1:0]                mem [DEPTH];
    logic [EW-1:0]                rd_data_reg;
    logic [KSW-1:0]               cmd_key_reg;
    logic [rfp_pkg::SIZE_W-1:0]   cmd_size_reg;
    logic [AW-1:0]                head_reg, head_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                rd_idx_reg, rd_idx_next;
    logic [CW-1:0]                wr_idx_reg, wr_idx_next;
    logic                         out_valid_reg, out_valid_next;
    rfp_pkg::rsp_item_t           out_reg, out_next;

    logic [AW-1:0]                rd_addr;
    logic [AW-1:0]                wr_addr;
    logic [EW-1:0]                wr_data;
    logic                         wr_en;
    logic [KSW-1:0]               rd_key;
    logic [rfp_pkg::SIZE_W-1:0]   rd_size;
    logic [CW-1:0]                dropped;
    logic [XW-1:0]                dropped_x;
    logic [rfp_pkg::REMOVED_W-1:0] removed_sat;

    // Circular address: base + offset, offset at most DEPTH
    function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(DEPTH))
        begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign rd_key  = rd_data_reg[rfp_pkg::SIZE_W +: KSW];
    assign rd_size = rd_data_reg[rfp_pkg::SIZE_W-1:0];

    assign rd_addr = wrap_add(head_reg, rd_idx_reg);
    assign wr_en   = cmd.append_wr | cmd.abort_wr;
    assign wr_addr = cmd.append_wr ? wrap_add(head_reg, count_reg)
                                   : wrap_add(head_reg, wr_idx_reg);
    assign wr_data = cmd.append_wr ? {cmd_key_reg, cmd_size_reg} : rd_data_reg;

    // Removed count saturates at the field maximum
    assign dropped     = count_reg - wr_idx_reg;
    assign dropped_x   = XW'(dropped);
    assign removed_sat = (dropped_x > XW'(rfp_pkg::REMOVED_MAX))
                         ? rfp_pkg::REMOVED_W'(rfp_pkg::REMOVED_MAX)
                         : dropped_x[rfp_pkg::REMOVED_W-1:0];

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (cmd.latch)
        begin
            rd_idx_next = '0;
            wr_idx_next = '0;
        end
        if (cmd.rd_en)
        begin
            rd_idx_next = rd_idx_reg + CW'(1);
        end
        if (cmd.abort_wr)
        begin
            wr_idx_next = wr_idx_reg + CW'(1);
        end
        if (cmd.append_wr)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.pop)
        begin
            count_next = count_reg - CW'(1);
            head_next  = wrap_add(head_reg, CW'(1));
        end
        if (cmd.commit_abort)
        begin
            count_next = wr_idx_reg;
        end

        if (cmd.emit)
        begin
            out_valid_next    = 1'b1;
            out_next.kind     = cmd.emit_kind;
            out_next.out_key  = cmd.emit_data ? rfp_pkg::KEY_W'(rd_key) : '0;
            out_next.out_size = cmd.emit_data ? rd_size : '0;
            out_next.removed  = cmd.commit_abort ? removed_sat : '0;
            out_next.last     = cmd.emit_last;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (cmd.latch)
        begin
            cmd_key_reg  <= req.req_key[KSW-1:0];
            cmd_size_reg <= req.req_size;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign status.empty    = (count_reg == '0);
    assign status.full     = (count_reg == CW'(DEPTH));
    assign status.rd_done  = (rd_idx_reg == count_reg);
    assign status.match    = (rd_key == cmd_key_reg);
    assign status.out_free = !out_valid_reg || rsp_ready;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule
`default_nettype wire

>>> hdl/rfp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfp_ctrl: command sequencer for the request queue
// Takes one request at a time and steps the datapath through append,
// fetch, print and the read/compact scan of abort.
// ----------------------------------------------------------------------------
module rfp_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     req_valid,
    input  rfp_pkg::action_t        req_action,
    input  rfp_pkg::dpath_status_t  status,
    output logic                    req_ready,
    output rfp_pkg::ctrl_cmd_t      cmd
);

    rfp_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rfp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        req_ready     = 1'b0;
        cmd           = '0;
        cmd.emit_kind = rfp_pkg::KIND_APPENDED;

        unique case (state_reg)
            rfp_pkg::ST_IDLE:
            begin
                req_ready = status.out_free;
                if (req_valid && status.out_free)
                begin
                    cmd.latch = 1'b1;
                    unique case (req_action)
                        rfp_pkg::ACT_APPEND: state_next = rfp_pkg::ST_APPEND;
                        rfp_pkg::ACT_ABORT:  state_next = rfp_pkg::ST_ABORT;
                        rfp_pkg::ACT_FETCH:  state_next = rfp_pkg::ST_FETCH;
                        rfp_pkg::ACT_PRINT:  state_next = rfp_pkg::ST_PRINT;
                    endcase
                end
            end

            rfp_pkg::ST_APPEND:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    if (status.full)
                    begin
                        cmd.emit_kind = rfp_pkg::KIND_REJECTED;
                    end
                    else
                    begin
                        cmd.append_wr = 1'b1;
                        cmd.emit_kind = rfp_pkg::KIND_APPENDED;
                    end
                    state_next = rfp_pkg::ST_IDLE;
                end
            end

            rfp_pkg::ST_FETCH:
            begin
                if (status.empty)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = rfp_pkg::KIND_FETCH_EMPTY;
                        cmd.emit_last = 1'b1;
                        state_next    = rfp_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = rfp_pkg::ST_FETCH_OUT;
                end
            end

            rfp_pkg::ST_FETCH_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = rfp_pkg::KIND_FETCHED;
                    cmd.emit_data = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.pop       = 1'b1;
                    state_next    = rfp_pkg::ST_IDLE;
                end
            end

            rfp_pkg::ST_PRINT:
            begin
                if (status.empty)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = rfp_pkg::KIND_PRINT_EMPTY;
                        cmd.emit_last = 1'b1;
                        state_next    = rfp_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = rfp_pkg::ST_PRINT_OUT;
                end
            end

            rfp_pkg::ST_PRINT_OUT:
            begin
                // Emit the entry in hand and fetch the next one together
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = rfp_pkg::KIND_PRINT_ENTRY;
                    cmd.emit_data = 1'b1;
                    cmd.emit_last = status.rd_done;
                    if (status.rd_done)
                    begin
                        state_next = rfp_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.rd_en = 1'b1;
                    end
                end
            end

            rfp_pkg::ST_ABORT:
            begin
                if (status.empty)
                begin
                    state_next = rfp_pkg::ST_ABORT_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = rfp_pkg::ST_ABORT_SCAN;
                end
            end

            rfp_pkg::ST_ABORT_SCAN:
            begin
                cmd.abort_wr = !status.match;
                if (status.rd_done)
                begin
                    state_next = rfp_pkg::ST_ABORT_DONE;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end

            rfp_pkg::ST_ABORT_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit         = 1'b1;
                    cmd.emit_kind    = rfp_pkg::KIND_ABORT_COUNT;
                    cmd.emit_last    = 1'b1;
                    cmd.commit_abort = 1'b1;
                    state_next       = rfp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rfp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/request_fifo_with_purge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// request_fifo_with_purge: ordered request queue with purge by key
// Bounded queue of key/size requests with append, abort-by-key, fetch and
// print, built as a sequencer driving a single-port-pair entry memory.
// ----------------------------------------------------------------------------
// One request is worked at a time: each append, fetch, print or abort runs
// to its end before the next request can be accepted. Print and abort step
// through the stored entries over the entry memory's single registered read
// port: print reads one entry a cycle while the output register can take a
// result, and abort compacts in place, reading one entry and writing back
// one kept entry a cycle. Results leave through a one-deep output register;
// any stall there holds the sequencer, and a new request is taken only when
// that register is empty or its result is being transferred in the same
// cycle. Entries are kept in a circular store, so fetch only advances the
// head. Keys are stored and compared on their low KEY_WIDTH bits (at most
// 32). The entry memory needs no clearing: only entries below the
// occupancy are ever read.
// ----------------------------------------------------------------------------
module request_fifo_with_purge #(
    parameter int DEPTH     = rfp_pkg::DEPTH_DEFAULT,
    parameter int KEY_WIDTH = rfp_pkg::KEY_WIDTH_DEFAULT
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_ready,
    input  rfp_pkg::req_item_t  req,
    output logic                rsp_valid,
    input  wire                 rsp_ready,
    output rfp_pkg::rsp_item_t  rsp
);

    rfp_pkg::ctrl_cmd_t     cmd;
    rfp_pkg::dpath_status_t status;

    // Sequencer: accept a request, then step the datapath
    rfp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_action (req.action),
        .status     (status),
        .req_ready  (req_ready),
        .cmd        (cmd)
    );

    // Datapath: entry memory, pointers and result register
    rfp_dpath #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .status    (status)
    );

    // Never write past the end of a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append_wr |-> !status.full)
        else $error("append write into a full queue");

    // Never drop the head of an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !status.empty)
        else $error("pop on an empty queue");

    // Never read beyond the tail
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> !status.rd_done)
        else $error("entry read beyond the tail");

    // Never overwrite a result that has not been transferred
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!rsp_valid || rsp_ready))
        else $error("result register overwritten before transfer");

endmodule
`default_nettype wire

>>> tb/request_fifo_with_purge_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// request_fifo_with_purge_test: self-checking bench for the request queue
// Drives append, abort, fetch and print commands through the request
// channel and tracks the queue in a scoreboard. Every result is compared
// field by field with the predicted one, under random idling on both sides.
// ----------------------------------------------------------------------------

class queue_tracker;

    logic [rfp_pkg::KEY_W-1:0]         held_keys[$];
    logic signed [rfp_pkg::SIZE_W-1:0] held_sizes[$];
    rfp_pkg::rsp_item_t                due_results[$];
    logic [rfp_pkg::KEY_W-1:0]         key_mask;
    int                                capacity;
    int                                mismatches;
    int                                checked;
    int                                peak_fill;
    int                                turned_away;
    int                                purged;
    int                                per_action[4];

    function new(int depth, int key_width);
        capacity = depth;
        key_mask = (key_width >= rfp_pkg::KEY_W)
                   ? {rfp_pkg::KEY_W{1'b1}}
                   : {rfp_pkg::KEY_W{1'b1}} >> (rfp_pkg::KEY_W - key_width);
    endfunction

    function void add_due(rfp_pkg::kind_t kind, logic [rfp_pkg::KEY_W-1:0] entry_key,
                          logic signed [rfp_pkg::SIZE_W-1:0] entry_size,
                          logic [rfp_pkg::REMOVED_W-1:0] removed, logic last);
        rfp_pkg::rsp_item_t item;
        item.kind     = kind;
        item.out_key  = entry_key;
        item.out_size = entry_size;
        item.removed  = removed;
        item.last     = last;
        due_results.push_back(item);
    endfunction

    // Advance the queue by one accepted command and queue its results.
    function void take_request(rfp_pkg::req_item_t r);
        logic [rfp_pkg::KEY_W-1:0] key;
        int                        hits;
        key  = r.req_key & key_mask;
        hits = 0;
        per_action[int'(r.action)]++;
        case (r.action)
            rfp_pkg::ACT_APPEND:
            begin
                if (held_keys.size() >= capacity)
                begin
                    turned_away++;
                    add_due(rfp_pkg::KIND_REJECTED, '0, '0, '0, 1'b1);
                end
                else
                begin
                    held_keys.push_back(key);
                    held_sizes.push_back(r.req_size);
                    if (held_keys.size() > peak_fill)
                        peak_fill = held_keys.size();
                    add_due(rfp_pkg::KIND_APPENDED, '0, '0, '0, 1'b1);
                end
            end
            rfp_pkg::ACT_ABORT:
            begin
                // Walk from the tail so deletion keeps the order of the rest.
                for (int i = held_keys.size() - 1; i >= 0; i--)
                begin
                    if (held_keys[i] == key)
                    begin
                        held_keys.delete(i);
                        held_sizes.delete(i);
                        hits++;
                    end
                end
                purged += hits;
                if (hits > rfp_pkg::REMOVED_MAX)
                    hits = rfp_pkg::REMOVED_MAX;
                add_due(rfp_pkg::KIND_ABORT_COUNT, '0, '0, rfp_pkg::REMOVED_W'(hits), 1'b1);
            end
            rfp_pkg::ACT_FETCH:
            begin
                if (held_keys.size() == 0)
                    add_due(rfp_pkg::KIND_FETCH_EMPTY, '0, '0, '0, 1'b1);
                else
                    add_due(rfp_pkg::KIND_FETCHED, held_keys.pop_front(),
                            held_sizes.pop_front(), '0, 1'b1);
            end
            default:
            begin
                if (held_keys.size() == 0)
                    add_due(rfp_pkg::KIND_PRINT_EMPTY, '0, '0, '0, 1'b1);
                for (int i = 0; i < held_keys.size(); i++)
                    add_due(rfp_pkg::KIND_PRINT_ENTRY, held_keys[i], held_sizes[i], '0,
                            i == held_keys.size() - 1);
            end
        endcase
    endfunction

    task report_mismatch(string note);
        $display("[%0t] mismatch: %s", $time, note);
        mismatches++;
    endtask

    // Compare one transferred result with the oldest prediction.
    task check_response(rfp_pkg::rsp_item_t got);
        rfp_pkg::rsp_item_t want;
        if (due_results.size() == 0)
        begin
            report_mismatch($sformatf("result kind %0d with nothing pending", got.kind));
            return;
        end
        want = due_results.pop_front();
        checked++;
        if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.out_key !== want.out_key)
            report_mismatch($sformatf("out_key %h, want %h", got.out_key, want.out_key));
        if (got.out_size !== want.out_size)
            report_mismatch($sformatf("out_size %0d, want %0d",
                                      got.out_size, want.out_size));
        if (got.removed !== want.removed)
            report_mismatch($sformatf("removed %0d, want %0d", got.removed, want.removed));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", got.last, want.last));
    endtask

endclass

module request_fifo_with_purge_test;

    localparam int DEPTH        = rfp_pkg::DEPTH_DEFAULT;
    localparam int KEY_WIDTH    = rfp_pkg::KEY_WIDTH_DEFAULT;
    localparam int RUN_LIMIT    = 400000;  // cycles; far above the slowest legal run
    localparam int DRAIN_CYCLES = 40;      // longer than a full print or abort
    localparam int PHASE_ITEMS  = 40;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    rfp_pkg::req_item_t req       = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    rfp_pkg::rsp_item_t rsp;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;

    queue_tracker tracker = new(DEPTH, KEY_WIDTH);

    request_fifo_with_purge #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: stop a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("watchdog: run stopped after %0d cycles, %0d results outstanding",
                     cycle_count, tracker.due_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: stall at random, change only on the falling edge.
    always @(negedge clk)
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Result monitor: check every transfer on the response channel.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            tracker.check_response(rsp);
    end

    function automatic rfp_pkg::req_item_t make_request(
        rfp_pkg::action_t action, logic [rfp_pkg::KEY_W-1:0] key,
        logic signed [rfp_pkg::SIZE_W-1:0] entry_size);
        rfp_pkg::req_item_t item;
        item.action   = action;
        item.req_key  = key;
        item.req_size = entry_size;
        return item;
    endfunction

    // Offer one command, idle first at random, and hold it until transfer.
    task automatic send_request(rfp_pkg::req_item_t item);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        tracker.take_request(item);
    endtask

    // Drop valid and hold off until every predicted result has arrived.
    task automatic hold_until_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (tracker.due_results.size() != 0)
            @(posedge clk);
    endtask

    // Random phase: keys mostly come from a small pool so aborts find matches.
    task automatic run_random_phase(int idle_pct, int stall_pct, int append_pct);
        logic [rfp_pkg::KEY_W-1:0]         key_pool[4];
        logic [rfp_pkg::KEY_W-1:0]         key;
        logic signed [rfp_pkg::SIZE_W-1:0] entry_size;
        rfp_pkg::action_t                  action;
        int                                pick;
        int                                rest;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        rest = (100 - append_pct - 15) / 2;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            pick = $urandom_range(99);
            if (pick < append_pct)
                action = rfp_pkg::ACT_APPEND;
            else if (pick < append_pct + 15)
                action = rfp_pkg::ACT_ABORT;
            else if (pick < append_pct + 15 + rest)
                action = rfp_pkg::ACT_FETCH;
            else
                action = rfp_pkg::ACT_PRINT;
            key        = ($urandom_range(99) < 85) ? key_pool[$urandom_range(3)] : $urandom;
            entry_size = $urandom;
            send_request(make_request(action, key, entry_size));
        end
    endtask

    initial
    begin
        logic [rfp_pkg::KEY_W-1:0]         dup_key;
        logic [rfp_pkg::KEY_W-1:0]         key;
        logic signed [rfp_pkg::SIZE_W-1:0] entry_size;

        dup_key = 32'h5A5A_00A5;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty-queue cases first.
        send_request(make_request(rfp_pkg::ACT_PRINT, '0, '0));
        send_request(make_request(rfp_pkg::ACT_FETCH, '0, '0));
        send_request(make_request(rfp_pkg::ACT_ABORT, '0, '0));

        // Fill the queue with extreme keys and sizes and a repeated key.
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
                key = '0;
            else if (i == 1)
                key = '1;
            else if (i % 3 == 2)
                key = dup_key;
            else
                key = $urandom;
            if (i == 0)
                entry_size = 32'sh8000_0000;
            else if (i == 1)
                entry_size = 32'sh7FFF_FFFF;
            else if (i == 2)
                entry_size = -1;
            else
                entry_size = $urandom;
            send_request(make_request(rfp_pkg::ACT_APPEND, key, entry_size));
        end

        // Full queue: append is turned away; print, two aborts, fetch, print.
        send_request(make_request(rfp_pkg::ACT_APPEND, 32'h0BAD_F00D, 32'sd7));
        send_request(make_request(rfp_pkg::ACT_PRINT, '0, '0));
        send_request(make_request(rfp_pkg::ACT_ABORT, dup_key, '0));
        send_request(make_request(rfp_pkg::ACT_ABORT, 32'hFFFF_FFFE, '0));
        send_request(make_request(rfp_pkg::ACT_FETCH, '0, '0));
        send_request(make_request(rfp_pkg::ACT_PRINT, '0, '0));

        // Pause the sender until the queue's answers have all come back.
        hold_until_drained();

        run_random_phase(0, 0, 55);
        run_random_phase(70, 0, 45);
        hold_until_drained();
        run_random_phase(0, 70, 50);
        run_random_phase(25, 25, 40);

        // Drain, then give the block time to show any stray result.
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d commands: %0d appends, %0d aborts, %0d fetches, %0d prints;",
                 tracker.per_action[0] + tracker.per_action[1] + tracker.per_action[2]
                 + tracker.per_action[3], tracker.per_action[0], tracker.per_action[1],
                 tracker.per_action[2], tracker.per_action[3]);
        $display("%0d results checked, peak fill %0d of %0d, %0d appends refused, %0d purged.",
                 tracker.checked, tracker.peak_fill, DEPTH, tracker.turned_away,
                 tracker.purged);
        if (tracker.mismatches == 0 && tracker.due_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hdl/rfp_pkg.sv
hdl/rfp_dpath.sv
hdl/rfp_ctrl.sv
hdl/request_fifo_with_purge.sv
tb/request_fifo_with_purge_test.sv
